>>> hw/rtl/color_temperature_to_rgb_top_defines.svh
// ----------------------------------------------------------------------------
// color temperature to rgb: assertion macros
// shared property forms for the checker of the top level
// ----------------------------------------------------------------------------
`ifndef COLOR_TEMPERATURE_TO_RGB_TOP_DEFINES_SVH
`define COLOR_TEMPERATURE_TO_RGB_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CTR_ASSERT_IMPL(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define CTR_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ctr_pkg.sv
// ----------------------------------------------------------------------------
// ctr_pkg
// constants, types and helpers of the color temperature to rgb block
// ----------------------------------------------------------------------------
`default_nettype none

package ctr_pkg;

  // default fraction bits of the results
  localparam int OUT_FRAC_BITS_DEF = 14;

  // internal fixed point: signed q28 values, products twice as wide
  localparam int QB = 28;
  localparam int VW = 34;
  localparam int PW = 2 * VW;
  localparam int OW = 16;

  // temperature limits and coefficient set boundaries
  localparam logic [15:0] T_MIN       = 16'd1000;
  localparam logic [15:0] T_MAX       = 16'd40000;
  localparam logic [15:0] T_SPLIT_LOW = 16'd4000;
  localparam logic [15:0] T_SPLIT_MID = 16'd7000;

  // 1000 in q28, numerator of s = 1000 / t
  localparam logic [37:0] S_NUM = 38'd268435456000;

  localparam logic signed [VW-1:0] C_ONE = 34'sd268435456;

  // chromaticity y = -3x^2 + 2.87x - 0.275
  localparam logic signed [VW-1:0] C_Y_LIN = 34'sd770409759;
  localparam logic signed [VW-1:0] C_Y_OFS = 34'sd73819750;

  // xyz to linear srgb matrix, middle column folded into an offset since y = 1
  localparam logic signed [VW-1:0] M_R_X = 34'sd869921467;
  localparam logic signed [VW-1:0] C_R_0 = 34'sd412655089;
  localparam logic signed [VW-1:0] M_R_Z = 34'sd133834134;
  localparam logic signed [VW-1:0] M_G_X = 34'sd260183213;
  localparam logic signed [VW-1:0] C_G_0 = 34'sd503582231;
  localparam logic signed [VW-1:0] M_G_Z = 34'sd11155023;
  localparam logic signed [VW-1:0] M_B_X = 34'sd14934460;
  localparam logic signed [VW-1:0] C_B_0 = 34'sd54759759;
  localparam logic signed [VW-1:0] M_B_Z = 34'sd283755067;

  // saturation limits of a 16-bit result
  localparam logic signed [OW-1:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [OW-1:0] OUT_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    SET_LOW  = 2'd0,
    SET_MID  = 2'd1,
    SET_HIGH = 2'd2
  } coef_set_t;

  typedef struct packed {
    logic signed [OW-1:0] red;
    logic signed [OW-1:0] green;
    logic signed [OW-1:0] blue;
  } out_item_t;

  // cubic coefficients of x in s, highest power first
  localparam logic signed [VW-1:0] COEF_LOW [4] = '{
    34'sd73752642, -34'sd264671991, 34'sd315261337, 34'sd39187818
  };
  localparam logic signed [VW-1:0] COEF_MID [4] = '{
    -34'sd1236682146, 34'sd796662746, 34'sd26604638, 34'sd65515163
  };
  localparam logic signed [VW-1:0] COEF_HIGH [4] = '{
    -34'sd538588899, 34'sd510510550, 34'sd66432407, 34'sd63629940
  };

  function automatic logic signed [VW-1:0] coef(input coef_set_t set, input logic [1:0] idx);
    logic signed [VW-1:0] val;
    unique case (set)
      SET_LOW: val = COEF_LOW[idx];
      SET_MID: val = COEF_MID[idx];
      default: val = COEF_HIGH[idx];
    endcase
    return val;
  endfunction

  // q28 product back to q28, rounded to nearest with halves away from zero
  function automatic logic signed [VW-1:0] qround(input logic signed [PW-1:0] p);
    logic [PW-1:0] mag;
    logic [PW-1:0] rnd;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    rnd = (mag + (PW'(1) << (QB - 1))) >> QB;
    return p[PW-1] ? -$signed(rnd[VW-1:0]) : $signed(rnd[VW-1:0]);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ctr_div.sv
// ----------------------------------------------------------------------------
// ctr_div
// pipelined restoring divider, one quotient bit per stage, with a side tag
// ----------------------------------------------------------------------------
`default_nettype none

module ctr_div #(
  parameter int NW = 38,
  parameter int DW = 16,
  parameter int QW = 29,
  parameter int TW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_v,
  output logic [QW-1:0] out_quo,
  output logic          out_ovf,
  output logic [TW-1:0] out_tag
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic          v_r   [QW+1];
  logic          ovf_r [QW+1];
  logic [QW-1:0] quo_r [QW+1];
  logic [TW-1:0] tag_r [QW+1];
  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];

  logic ovf_nxt;

  // quotient would not fit in QW bits
  assign ovf_nxt = CW'(in_num) >= (CW'(in_den) << QW);

  // entry stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  // entry stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= in_num;
      den_r[0] <= in_den;
      quo_r[0] <= '0;
      ovf_r[0] <= ovf_nxt;
      tag_r[0] <= in_tag;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;

    logic [CW-1:0] rem_ext;
    logic [CW-1:0] den_sh;
    logic [CW-1:0] diff;
    logic          take;
    logic [QW-1:0] quo_nxt;

    // trial subtract of the shifted divisor
    always_comb begin
      rem_ext     = CW'(rem_r[k]);
      den_sh      = CW'(den_r[k]) << SH;
      take        = rem_ext >= den_sh;
      diff        = rem_ext - den_sh;
      quo_nxt     = quo_r[k];
      quo_nxt[SH] = take;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k+1] <= quo_nxt;
        ovf_r[k+1] <= ovf_r[k];
        tag_r[k+1] <= tag_r[k];
      end
    end

    // remainder and divisor only travel while bits remain
    if (k + 1 < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= take ? NW'(diff) : rem_r[k];
          den_r[k+1] <= den_r[k];
        end
      end
    end
  end

  assign out_v   = v_r[QW];
  assign out_quo = quo_r[QW];
  assign out_ovf = ovf_r[QW];
  assign out_tag = tag_r[QW];

endmodule

`default_nettype wire

>>> hw/rtl/color_temperature_to_rgb_top.sv
// ----------------------------------------------------------------------------
// color_temperature_to_rgb_top
// color temperature in kelvin to normalized linear srgb along the daylight locus
// ----------------------------------------------------------------------------
// A fully pipelined unit: it takes one temperature item per clock while
// in_stall is low and delivers its red, green and blue. The pipeline is
// made of the three pipelined dividers (1000/T with 29 quotient
// bits, X and Z with 31 bits each, the normalization with 16 bits plus a
// saturation flag), one quotient bit per stage, plus eight stages for the
// cubic and quadratic, three for the matrix and maximum and one output
// register. A two-entry output buffer lets the unit keep accepting items
// while a finished result waits; in_stall rises only when that buffer is
// full and the result side stalls. Results are signed with OUT_FRAC_BITS
// fraction bits and saturate to 16 bits; the largest component is exactly 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module color_temperature_to_rgb_top #(
  parameter int OUT_FRAC_BITS = ctr_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_temperature_k,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_red,
  output logic signed [15:0] out_green,
  output logic signed [15:0] out_blue
);

  import ctr_pkg::*;

  localparam int S_NW = 38;
  localparam int S_QW = 29;
  localparam int X_NW = VW + QB;
  localparam int X_QW = 31;
  localparam int F_NW = VW + OUT_FRAC_BITS;
  localparam int F_QW = 16;

  logic adv;

  // ---------------- clamp and 1000/T ----------------
  logic [15:0]     t_c;
  coef_set_t       set_c;
  logic [S_NW-1:0] s_num;

  // clamp and pick the coefficient set
  always_comb begin
    priority if (in_temperature_k < T_MIN) begin
      t_c = T_MIN;
    end else if (in_temperature_k > T_MAX) begin
      t_c = T_MAX;
    end else begin
      t_c = in_temperature_k;
    end
    priority if (t_c <= T_SPLIT_LOW) begin
      set_c = SET_LOW;
    end else if (t_c <= T_SPLIT_MID) begin
      set_c = SET_MID;
    end else begin
      set_c = SET_HIGH;
    end
    s_num = S_NUM + S_NW'(t_c >> 1);
  end

  logic            sd_v;
  logic [S_QW-1:0] sd_quo;
  logic            sd_ovf;
  logic [1:0]      sd_tag;

  ctr_div #(.NW(S_NW), .DW(16), .QW(S_QW), .TW(2)) u_div_s (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_v    (in_valid),
    .in_num  (s_num),
    .in_den  (t_c),
    .in_tag  (set_c),
    .out_v   (sd_v),
    .out_quo (sd_quo),
    .out_ovf (sd_ovf),
    .out_tag (sd_tag)
  );

  logic signed [VW-1:0] s_sx;
  coef_set_t            s_set;

  assign s_sx  = $signed(VW'(sd_ovf ? {S_QW{1'b1}} : sd_quo));
  assign s_set = coef_set_t'(sd_tag);

  // ---------------- cubic in s, horner form ----------------
  logic                 a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r, g_v_r, h_v_r;
  logic signed [PW-1:0] a_p_r, c_p_r, e_p_r, g_sq_r, g_lin_r;
  logic signed [VW-1:0] a_s_r, b_s_r, c_s_r, d_s_r;
  logic signed [VW-1:0] b_x_r, d_x_r, f_x_r, g_x_r, h_x_r, h_y_r;
  coef_set_t            a_set_r, b_set_r, c_set_r, d_set_r, e_set_r;

  logic signed [VW-1:0] sq_q;
  logic signed [VW-1:0] y_c;

  // y = -3x^2 + 2.87x - 0.275, floored at one step
  always_comb begin
    sq_q = qround(g_sq_r);
    y_c  = qround(g_lin_r) - C_Y_OFS - sq_q - (sq_q <<< 1);
    if (y_c < $signed(VW'(1))) begin
      y_c = $signed(VW'(1));
    end
  end

  // stage valids for the polynomial part
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
      h_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= sd_v;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
      g_v_r <= f_v_r;
      h_v_r <= g_v_r;
    end
  end

  // multiply and round-add stages alternate
  always_ff @(posedge clk) begin
    if (adv) begin
      a_p_r   <= PW'(coef(s_set, 2'd0)) * PW'(s_sx);
      a_s_r   <= s_sx;
      a_set_r <= s_set;

      b_x_r   <= qround(a_p_r) + coef(a_set_r, 2'd1);
      b_s_r   <= a_s_r;
      b_set_r <= a_set_r;

      c_p_r   <= PW'(b_x_r) * PW'(b_s_r);
      c_s_r   <= b_s_r;
      c_set_r <= b_set_r;

      d_x_r   <= qround(c_p_r) + coef(c_set_r, 2'd2);
      d_s_r   <= c_s_r;
      d_set_r <= c_set_r;

      e_p_r   <= PW'(d_x_r) * PW'(d_s_r);
      e_set_r <= d_set_r;

      f_x_r   <= qround(e_p_r) + coef(e_set_r, 2'd3);

      g_sq_r  <= PW'(f_x_r) * PW'(f_x_r);
      g_lin_r <= PW'(C_Y_LIN) * PW'(f_x_r);
      g_x_r   <= f_x_r;

      h_x_r   <= g_x_r;
      h_y_r   <= y_c;
    end
  end

  // ---------------- X = x/y and Z = (1-x-y)/y ----------------
  logic signed [VW-1:0] zn_c;
  logic [VW-1:0]        ax_c, az_c, yu_c;
  logic [X_NW-1:0]      xn_c, zd_c;

  always_comb begin
    zn_c = C_ONE - h_x_r - h_y_r;
    ax_c = h_x_r[VW-1] ? -h_x_r : h_x_r;
    az_c = zn_c[VW-1] ? -zn_c : zn_c;
    yu_c = h_y_r;
    xn_c = {ax_c, {QB{1'b0}}} + X_NW'(yu_c >> 1);
    zd_c = {az_c, {QB{1'b0}}} + X_NW'(yu_c >> 1);
  end

  logic            xd_v;
  logic [X_QW-1:0] xd_quo, zdv_quo;
  logic            xd_ovf, zdv_ovf;
  logic [0:0]      xd_neg, zdv_neg;

  ctr_div #(.NW(X_NW), .DW(VW), .QW(X_QW), .TW(1)) u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_v    (h_v_r),
    .in_num  (xn_c),
    .in_den  (yu_c),
    .in_tag  (h_x_r[VW-1]),
    .out_v   (xd_v),
    .out_quo (xd_quo),
    .out_ovf (xd_ovf),
    .out_tag (xd_neg)
  );

  ctr_div #(.NW(X_NW), .DW(VW), .QW(X_QW), .TW(1)) u_div_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_v    (h_v_r),
    .in_num  (zd_c),
    .in_den  (yu_c),
    .in_tag  (zn_c[VW-1]),
    .out_v   (),
    .out_quo (zdv_quo),
    .out_ovf (zdv_ovf),
    .out_tag (zdv_neg)
  );

  logic signed [VW-1:0] bx_c, bz_c;
  logic [X_QW-1:0]      bxm_c, bzm_c;

  // apply sign, saturate a quotient that could not fit
  always_comb begin
    bxm_c = xd_ovf ? {X_QW{1'b1}} : xd_quo;
    bzm_c = zdv_ovf ? {X_QW{1'b1}} : zdv_quo;
    bx_c  = xd_neg[0] ? -$signed(VW'(bxm_c)) : $signed(VW'(bxm_c));
    bz_c  = zdv_neg[0] ? -$signed(VW'(bzm_c)) : $signed(VW'(bzm_c));
  end

  // ---------------- matrix and maximum ----------------
  logic                 j_v_r, k_v_r, l_v_r;
  logic signed [PW-1:0] j_rx_r, j_rz_r, j_gx_r, j_gz_r, j_bx_r, j_bz_r;
  logic signed [VW-1:0] k_r_r, k_g_r, k_b_r;
  logic signed [VW-1:0] l_r_r, l_g_r, l_b_r, l_m_r;
  logic signed [VW-1:0] m_c;

  // largest of the three components
  always_comb begin
    m_c = k_r_r;
    if (k_g_r > m_c) begin
      m_c = k_g_r;
    end
    if (k_b_r > m_c) begin
      m_c = k_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_v_r <= 1'b0;
      k_v_r <= 1'b0;
      l_v_r <= 1'b0;
    end else if (adv) begin
      j_v_r <= xd_v;
      k_v_r <= j_v_r;
      l_v_r <= k_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_rx_r <= PW'(M_R_X) * PW'(bx_c);
      j_rz_r <= PW'(M_R_Z) * PW'(bz_c);
      j_gx_r <= PW'(M_G_X) * PW'(bx_c);
      j_gz_r <= PW'(M_G_Z) * PW'(bz_c);
      j_bx_r <= PW'(M_B_X) * PW'(bx_c);
      j_bz_r <= PW'(M_B_Z) * PW'(bz_c);

      k_r_r  <= qround(j_rx_r) - C_R_0 - qround(j_rz_r);
      k_g_r  <= C_G_0 - qround(j_gx_r) + qround(j_gz_r);
      k_b_r  <= qround(j_bx_r) - C_B_0 + qround(j_bz_r);

      l_r_r  <= k_r_r;
      l_g_r  <= k_g_r;
      l_b_r  <= k_b_r;
      l_m_r  <= m_c;
    end
  end

  // ---------------- normalization by the maximum ----------------
  logic            zero_c;
  logic [VW-1:0]   mu_c, ar_c, ag_c, ab_c;
  logic [F_NW-1:0] nr_c, ng_c, nb_c;

  always_comb begin
    zero_c = l_m_r[VW-1] || (l_m_r == '0);
    mu_c   = l_m_r;
    ar_c   = l_r_r[VW-1] ? -l_r_r : l_r_r;
    ag_c   = l_g_r[VW-1] ? -l_g_r : l_g_r;
    ab_c   = l_b_r[VW-1] ? -l_b_r : l_b_r;
    nr_c   = {ar_c, {OUT_FRAC_BITS{1'b0}}} + F_NW'(mu_c >> 1);
    ng_c   = {ag_c, {OUT_FRAC_BITS{1'b0}}} + F_NW'(mu_c >> 1);
    nb_c   = {ab_c, {OUT_FRAC_BITS{1'b0}}} + F_NW'(mu_c >> 1);
  end

  logic            fr_v;
  logic [F_QW-1:0] fr_quo, fg_quo, fb_quo;
  logic            fr_ovf, fg_ovf, fb_ovf;
  logic [1:0]      fr_tag, fg_tag, fb_tag;

  ctr_div #(.NW(F_NW), .DW(VW), .QW(F_QW), .TW(2)) u_div_r (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_v    (l_v_r),
    .in_num  (nr_c),
    .in_den  (mu_c),
    .in_tag  ({zero_c, l_r_r[VW-1]}),
    .out_v   (fr_v),
    .out_quo (fr_quo),
    .out_ovf (fr_ovf),
    .out_tag (fr_tag)
  );

  ctr_div #(.NW(F_NW), .DW(VW), .QW(F_QW), .TW(2)) u_div_g (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_v    (l_v_r),
    .in_num  (ng_c),
    .in_den  (mu_c),
    .in_tag  ({zero_c, l_g_r[VW-1]}),
    .out_v   (),
    .out_quo (fg_quo),
    .out_ovf (fg_ovf),
    .out_tag (fg_tag)
  );

  ctr_div #(.NW(F_NW), .DW(VW), .QW(F_QW), .TW(2)) u_div_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_v    (l_v_r),
    .in_num  (nb_c),
    .in_den  (mu_c),
    .in_tag  ({zero_c, l_b_r[VW-1]}),
    .out_v   (),
    .out_quo (fb_quo),
    .out_ovf (fb_ovf),
    .out_tag (fb_tag)
  );

  // sign, saturation and the all-zero case; tag is {zero, negative}
  function automatic logic signed [OW-1:0] finish(input logic [F_QW-1:0] q,
                                                   input logic ovf,
                                                   input logic [1:0] tag);
    logic signed [OW-1:0] val;
    priority if (tag[1]) begin
      val = '0;
    end else if (tag[0]) begin
      if (ovf || (q > F_QW'(32768))) begin
        val = OUT_MIN;
      end else begin
        val = -$signed(OW'(q));
      end
    end else begin
      if (ovf || (q > F_QW'(32767))) begin
        val = OUT_MAX;
      end else begin
        val = $signed(OW'(q));
      end
    end
    return val;
  endfunction

  out_item_t fin_c;

  always_comb begin
    fin_c.red   = finish(fr_quo, fr_ovf, fr_tag);
    fin_c.green = finish(fg_quo, fg_ovf, fg_tag);
    fin_c.blue  = finish(fb_quo, fb_ovf, fb_tag);
  end

  // ---------------- two-entry output buffer ----------------
  out_item_t  fifo_mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fifo_cnt_r;
  logic       push, pop;

  assign adv      = (fifo_cnt_r != 2'd2) || !out_stall;
  assign in_stall = !adv;
  assign push     = adv && fr_v;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      fifo_cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fifo_cnt_r <= fifo_cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem_r[wr_ptr_r] <= fin_c;
    end
  end

  assign out_valid = fifo_cnt_r != 2'd0;
  assign out_red   = fifo_mem_r[rd_ptr_r].red;
  assign out_green = fifo_mem_r[rd_ptr_r].green;
  assign out_blue  = fifo_mem_r[rd_ptr_r].blue;

endmodule

`default_nettype wire

>>> hw/rtl/ctr_chk.sv
// ----------------------------------------------------------------------------
// ctr_chk
// port-level checks of the color temperature to rgb top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "color_temperature_to_rgb_top_defines.svh"

module ctr_chk #(
  parameter int OUT_FRAC_BITS = ctr_pkg::OUT_FRAC_BITS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_red,
  input logic signed [15:0] out_green,
  input logic signed [15:0] out_blue
);

  import ctr_pkg::*;

  // 1.0 at the output scale, saturated
  localparam logic signed [15:0] ONE_Q =
    (OUT_FRAC_BITS >= 15) ? OUT_MAX : 16'(1 << OUT_FRAC_BITS);

  // a stalled item stays put
  `CTR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "item dropped")
  `CTR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_red) && $stable(out_green) && $stable(out_blue), "item changed")

  // the largest component is exactly one, or all are zero
  `CTR_ASSERT_IMPL(a_max_one, clk, rst_n, out_valid, out_red == ONE_Q || out_green == ONE_Q || out_blue == ONE_Q || (out_red == 16'sd0 && out_green == 16'sd0 && out_blue == 16'sd0), "no unit component")

  // no component exceeds one
  `CTR_ASSERT_IMPL(a_le_one, clk, rst_n, out_valid, out_red <= ONE_Q && out_green <= ONE_Q && out_blue <= ONE_Q, "component above one")

  // input never stalls while the output buffer is empty
  `CTR_ASSERT_IMPL(a_no_idle_stall, clk, rst_n, !out_valid, !in_stall, "stall with empty buffer")

endmodule

bind color_temperature_to_rgb_top ctr_chk #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_ctr_chk (.*);

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// random and directed test of the color temperature to rgb unit
// ----------------------------------------------------------------------------
// Temperatures are offered with random gaps while the result side stalls at
// random, once for a long stretch so the pipeline backs up. Each accepted
// temperature is run through a fixed-point model of the daylight locus and
// the srgb conversion, and each result is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ctr_pkg::*;

  localparam int N_RANDOM = 1330;
  localparam longint ONE = 64'sd1 << 28;

  // fixed-point model of one temperature
  function automatic longint mul_q(longint a, longint b);
    longint p;
    longint m;
    p = a * b;
    m = ((p < 0 ? -p : p) + (64'sd1 << 27)) >>> 28;
    return p < 0 ? -m : m;
  endfunction

  function automatic longint div_near(longint n, longint d);
    longint m;
    m = ((n < 0 ? -n : n) + d / 2) / d;
    return n < 0 ? -m : m;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint qc(longint n, longint d);
    return (n * ONE + d / 2) / d;
  endfunction

  function automatic out_item_t daylight_rgb(logic [15:0] temp);
    longint t, s, x, y, zn, bx, bz, m;
    longint c [4];
    longint rgb [3];
    out_item_t r;
    t = temp;
    if (t < 1000) t = 1000;
    if (t > 40000) t = 40000;
    s = (1000 * ONE + t / 2) / t;
    if (t <= 4000)
      c = '{qc(27475, 100000), -qc(98598, 100000), qc(117444, 100000), qc(145986, 1000000)};
    else if (t <= 7000)
      c = '{-qc(46070, 10000), qc(29678, 10000), qc(9911, 100000), qc(244063, 1000000)};
    else
      c = '{-qc(20064, 10000), qc(19018, 10000), qc(24748, 100000), qc(237040, 1000000)};
    x = mul_q(c[0], s) + c[1];
    x = mul_q(x, s) + c[2];
    x = mul_q(x, s) + c[3];
    y = -3 * mul_q(x, x) + mul_q(qc(287, 100), x) - qc(275, 1000);
    if (y < 1) y = 1;
    zn = ONE - x - y;
    bx = div_near(x * ONE, y);
    bz = div_near(zn * ONE, y);
    rgb[0] = mul_q(qc(324071, 100000), bx) - qc(153726, 100000)
           - mul_q(qc(498571, 1000000), bz);
    rgb[1] = -mul_q(qc(969258, 1000000), bx) + qc(187599, 100000)
           + mul_q(qc(415557, 10000000), bz);
    rgb[2] = mul_q(qc(556352, 10000000), bx) - qc(203996, 1000000)
           + mul_q(qc(105707, 100000), bz);
    m = rgb[0];
    if (rgb[1] > m) m = rgb[1];
    if (rgb[2] > m) m = rgb[2];
    if (m <= 0) begin
      r = '0;
    end else begin
      r.red   = clip16(div_near(rgb[0] * (64'sd1 << OUT_FRAC_BITS_DEF), m));
      r.green = clip16(div_near(rgb[1] * (64'sd1 << OUT_FRAC_BITS_DEF), m));
      r.blue  = clip16(div_near(rgb[2] * (64'sd1 << OUT_FRAC_BITS_DEF), m));
    end
    return r;
  endfunction

  // scoreboard of predicted colors
  class color_board;
    out_item_t pending_rgb[$];
    int errors;

    function void note_temperature(logic [15:0] temp);
      pending_rgb.push_back(daylight_rgb(temp));
    endfunction

    function void check_color(out_item_t got);
      out_item_t exp;
      if (pending_rgb.size() == 0) begin
        $error("unexpected result %0d %0d %0d", got.red, got.green, got.blue);
        errors++;
        return;
      end
      exp = pending_rgb.pop_front();
      if (got.red !== exp.red) begin
        $error("red: expected %0d, got %0d", exp.red, got.red);
        errors++;
      end
      if (got.green !== exp.green) begin
        $error("green: expected %0d, got %0d", exp.green, got.green);
        errors++;
      end
      if (got.blue !== exp.blue) begin
        $error("blue: expected %0d, got %0d", exp.blue, got.blue);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_temperature_k = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_red, out_green, out_blue;

  color_board board = new();
  bit driving_done = 1'b0;
  bit calm = 1'b0;
  int cycle = 0;

  color_temperature_to_rgb_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_temperature_k(in_temperature_k),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle <= cycle + 1;

  // note accepted items and check results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_temperature(in_temperature_k);
      if (out_valid && !out_stall) board.check_color('{out_red, out_green, out_blue});
    end
  end

  // offer one temperature, with a random gap first unless calm
  task automatic send_temperature(logic [15:0] temp);
    if (!calm) begin
      while ($urandom_range(99) < 25) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_temperature_k <= temp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_temperature();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'($urandom_range(999));
      2: return 16'($urandom_range(65535, 40001));
      3: return 16'($urandom_range(4100, 3900));
      4: return 16'($urandom_range(7100, 6900));
      default: return 16'($urandom_range(40000, 1000));
    endcase
  endfunction

  // receiver: random stalls, one long hold-off, calm stretch
  initial begin
    int hold;
    @(posedge rst_n);
    while (!driving_done || board.pending_rgb.size() != 0) begin
      @(negedge clk);
      if (cycle > 1200 && cycle < 1210) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < 300; hold++) @(negedge clk);
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 25);
    end
    out_stall <= 1'b0;
  end

  initial begin
    logic [15:0] directed [$];
    directed = '{16'd0, 16'd1, 16'd999, 16'd1000, 16'd1001, 16'd3999, 16'd4000,
                 16'd4001, 16'd6999, 16'd7000, 16'd7001, 16'd6500, 16'd39999,
                 16'd40000, 16'd40001, 16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA,
                 16'd2000, 16'd25000};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_temperature(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 600 && i < 800);
      send_temperature(pick_temperature());
    end
    @(negedge clk);
    in_valid <= 1'b0;
    driving_done = 1'b1;
    while (board.pending_rgb.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (board.errors == 0)
      $display("** color_temperature_to_rgb_top: PASSED **");
    else
      $display("** color_temperature_to_rgb_top: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("** color_temperature_to_rgb_top: FAILED **");
    $finish;
  end
endmodule
